// ===== sv/kbe_pkg.sv =====
// Shared types, command codes and reply constants of the keyboard event encoder.
package kbe_pkg;

  localparam int QueueDepth = 4;
  localparam int MaxBytes   = 7;

  // Input actions
  localparam logic [1:0] ACT_COMMAND  = 2'd0;
  localparam logic [1:0] ACT_KEY      = 2'd1;
  localparam logic [1:0] ACT_JOYSTICK = 2'd2;
  localparam logic [1:0] ACT_MOUSE    = 2'd3;

  // Host command codes
  localparam logic [7:0] CMD_BUTTON_ACTION = 8'h07;
  localparam logic [7:0] CMD_MOUSE_REL     = 8'h08;
  localparam logic [7:0] CMD_MOUSE_ABS     = 8'h09;
  localparam logic [7:0] CMD_MOUSE_SCALE   = 8'h0B;
  localparam logic [7:0] CMD_Y_BOTTOM      = 8'h0F;
  localparam logic [7:0] CMD_Y_TOP         = 8'h10;
  localparam logic [7:0] CMD_MOUSE_OFF     = 8'h12;
  localparam logic [7:0] CMD_JOY_EVENTS    = 8'h14;
  localparam logic [7:0] CMD_JOY_POLLED    = 8'h15;
  localparam logic [7:0] CMD_JOY_QUERY     = 8'h16;
  localparam logic [7:0] CMD_JOY_OFF       = 8'h1A;
  localparam logic [7:0] CMD_TIME_QUERY    = 8'h1C;
  localparam logic [7:0] CMD_RESET         = 8'h80;

  // Reply header bytes
  localparam logic [7:0] HDR_MOUSE_REL = 8'hF8;
  localparam logic [7:0] HDR_JOY_STAT  = 8'hFD;
  localparam logic [7:0] HDR_TIME      = 8'hFC;
  localparam logic [7:0] HDR_RESET_OK  = 8'hF0;
  localparam logic [6:0] HDR_JOY_EVENT = 7'h7F;  // 0xFE plus joystick index
  localparam logic [6:0] KEY_LEFT_BTN  = 7'h74;
  localparam logic [6:0] KEY_RIGHT_BTN = 7'h75;

  localparam logic [MaxBytes-1:0][7:0] TIME_REPLY =
      {8'h00, 8'h58, 8'h20, 8'h07, 8'h03, 8'h13, HDR_TIME};

  // Mode flag bit positions
  localparam int FL_JOY_REPORT = 0;
  localparam int FL_Y_BOTTOM   = 1;
  localparam int FL_BTN_KEYS   = 2;
  localparam int FL_MOUSE_OFF  = 3;
  localparam int FL_ABSOLUTE   = 4;
  localparam logic [4:0] FLAGS_RESET = 5'b00001;

  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        byte_value;
    logic              joy_index;
    logic [4:0]        joy_map;
    logic [1:0]        btn_pressed;
    logic signed [7:0] mouse_dx;
    logic signed [7:0] mouse_dy;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  // Reply bytes of one request, handed from front to back
  typedef struct packed {
    logic [2:0]                count;
    logic [MaxBytes-1:0][7:0] bytes;
  } reply_t;

  function automatic logic [7:0] joy_convert(input logic [4:0] map);
    joy_convert = {map[4], 3'b000, map[3:0]};
  endfunction

endpackage

// ===== sv/kbe_front.sv =====
// Front end: parses host commands, tracks modes and builds the reply of each request.
module kbe_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  kbe_pkg::item_t item,
  input  logic           q_full,
  output logic           q_push,
  output kbe_pkg::reply_t q_data
);
  import kbe_pkg::*;

  logic [7:0]      pending_command, pending_command_next;
  logic [2:0]      bytes_expected, bytes_expected_next;
  logic [4:0]      mode_flags, mode_flags_next;
  logic [1:0][4:0] joystick_last, joystick_last_next;
  logic [1:0]      buttons_last, buttons_last_next;

  reply_t          rep;
  logic [2:0]      n;
  logic            do_mouse;
  logic [1:0]      m_btn;
  logic [7:0]      m_dx, m_dy;
  logic [1:0]      b, diff;
  logic            accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && (rep.count != 3'd0);
  assign q_data = rep;

  always_comb begin
    pending_command_next = pending_command;
    bytes_expected_next  = bytes_expected;
    mode_flags_next      = mode_flags;
    joystick_last_next   = joystick_last;
    buttons_last_next    = buttons_last;
    rep      = '0;
    n        = 3'd0;
    do_mouse = 1'b0;
    m_btn    = 2'b00;
    m_dx     = 8'h00;
    m_dy     = 8'h00;
    b        = 2'b00;
    diff     = 2'b00;

    unique case (item.action)
      ACT_COMMAND: begin
        if (bytes_expected != 3'd0) begin
          // Parameter byte: consume; the last one of a button action sets the button-key mode
          bytes_expected_next = bytes_expected - 3'd1;
          if (bytes_expected == 3'd1) begin
            if (pending_command == CMD_BUTTON_ACTION) begin
              mode_flags_next[FL_BTN_KEYS] = item.byte_value[2];
            end else if (pending_command == CMD_RESET) begin
              rep.bytes[n] = HDR_RESET_OK;
              n = n + 3'd1;
            end
          end
        end else begin
          pending_command_next = item.byte_value;
          unique case (item.byte_value) inside
            CMD_BUTTON_ACTION: bytes_expected_next = 3'd1;
            CMD_MOUSE_REL: begin
              mode_flags_next[FL_MOUSE_OFF] = 1'b0;
              mode_flags_next[FL_ABSOLUTE]  = 1'b0;
            end
            CMD_MOUSE_ABS: begin
              mode_flags_next[FL_MOUSE_OFF] = 1'b0;
              mode_flags_next[FL_ABSOLUTE]  = 1'b1;
              bytes_expected_next = 3'd4;
            end
            CMD_MOUSE_SCALE: bytes_expected_next = 3'd2;
            CMD_Y_BOTTOM:    mode_flags_next[FL_Y_BOTTOM]   = 1'b1;
            CMD_Y_TOP:       mode_flags_next[FL_Y_BOTTOM]   = 1'b0;
            CMD_MOUSE_OFF:   mode_flags_next[FL_MOUSE_OFF]  = 1'b1;
            CMD_JOY_EVENTS:  mode_flags_next[FL_JOY_REPORT] = 1'b1;
            CMD_JOY_POLLED, CMD_JOY_OFF: mode_flags_next[FL_JOY_REPORT] = 1'b0;
            CMD_JOY_QUERY: begin
              rep.bytes[0] = HDR_JOY_STAT;
              rep.bytes[1] = joy_convert(joystick_last[0]);
              rep.bytes[2] = joy_convert(joystick_last[1]);
              n = 3'd3;
            end
            CMD_TIME_QUERY: begin
              rep.bytes = TIME_REPLY;
              n = 3'd7;
            end
            CMD_RESET: begin
              bytes_expected_next = 3'd1;
              mode_flags_next     = FLAGS_RESET;
            end
            default: ;
          endcase
        end
      end
      ACT_KEY: begin
        rep.bytes[n] = item.byte_value;
        n = n + 3'd1;
      end
      ACT_JOYSTICK: begin
        joystick_last_next[item.joy_index] = item.joy_map;
        if (mode_flags[FL_JOY_REPORT]) begin
          if (mode_flags[FL_MOUSE_OFF] || item.joy_index) begin
            rep.bytes[n] = {HDR_JOY_EVENT, item.joy_index};
            n = n + 3'd1;
            rep.bytes[n] = joy_convert(item.joy_map);
            n = n + 3'd1;
          end
          // A fire change acts as a mouse event with no motion
          if (!mode_flags[FL_MOUSE_OFF] &&
              (item.joy_map[4] != joystick_last[item.joy_index][4])) begin
            do_mouse = 1'b1;
          end
        end
      end
      ACT_MOUSE: begin
        do_mouse = 1'b1;
        m_btn    = item.btn_pressed;
        m_dx     = item.mouse_dx;
        m_dy     = item.mouse_dy;
      end
      default: ;
    endcase

    if (do_mouse && !mode_flags[FL_MOUSE_OFF]) begin
      // Merge joystick fire into the buttons
      b    = m_btn | {joystick_last_next[1][4], joystick_last_next[0][4]};
      diff = b ^ buttons_last;
      if (diff != 2'b00) begin
        if (mode_flags[FL_BTN_KEYS]) begin
          if (diff[0]) begin
            rep.bytes[n] = {~b[0], KEY_LEFT_BTN};
            n = n + 3'd1;
          end
          if (diff[1]) begin
            rep.bytes[n] = {~b[1], KEY_RIGHT_BTN};
            n = n + 3'd1;
          end
        end
        buttons_last_next = b;
      end
      if (!mode_flags[FL_ABSOLUTE]) begin
        rep.bytes[n] = HDR_MOUSE_REL | {6'b000000, b[0], b[1]};
        n = n + 3'd1;
        rep.bytes[n] = m_dx;
        n = n + 3'd1;
        rep.bytes[n] = mode_flags[FL_Y_BOTTOM] ? (8'h00 - m_dy) : m_dy;
        n = n + 3'd1;
      end
    end
    rep.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_command <= '0;
      bytes_expected  <= '0;
      mode_flags      <= FLAGS_RESET;
      joystick_last   <= '0;
      buttons_last    <= '0;
    end else if (accept) begin
      pending_command <= pending_command_next;
      bytes_expected  <= bytes_expected_next;
      mode_flags      <= mode_flags_next;
      joystick_last   <= joystick_last_next;
      buttons_last    <= buttons_last_next;
    end
  end

endmodule

// ===== sv/kbe_queue.sv =====
// Short reply queue between the front end and the byte serializer.
module kbe_queue #(
  parameter int DEPTH = kbe_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  kbe_pkg::reply_t wdata,
  output logic            full,
  input  logic            rd,
  output kbe_pkg::reply_t rdata,
  output logic            empty
);
  import kbe_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  reply_t        slots [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== sv/kbe_back.sv =====
// Back end: sends the queued replies one byte at a time through an output register.
module kbe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  kbe_pkg::reply_t  q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output kbe_pkg::result_t result
);
  import kbe_pkg::*;

  logic       out_valid;
  result_t    out_reg;
  logic [2:0] idx;
  logic       load, take, is_last;

  assign load    = !out_valid || pop;
  assign take    = load && !q_empty;
  assign is_last = (idx == q_data.count - 3'd1);
  assign q_pop   = take && is_last;
  assign empty   = !out_valid;
  assign result  = out_reg;

  always_ff @(posedge clk) begin
    if (take) begin
      out_reg.out_byte <= q_data.bytes[idx];
      out_reg.last     <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= !q_empty;
      end
      if (take) begin
        // Advance within the reply, wrap at its final byte
        idx <= is_last ? 3'd0 : idx + 3'd1;
      end
    end
  end

endmodule

// ===== sv/keyboard_controller_event_encoder_core.sv =====
// Top level of the keyboard controller event encoder.
//
// Input channel (push/full): one request per accepted item; action selects a
// host command byte, a key code, a joystick event or a mouse event. The front
// end updates the mode state and builds the whole reply of the request in the
// cycle it is accepted, so a request can be taken at every clock edge while
// the reply queue has room (QUEUE_DEPTH replies; requests without reply bytes
// never enter it, though full still holds them off).
// Result channel (empty/pop): one reply byte at a time, last set on the final
// byte of a request. The first byte of a request is written into the queue, then
// moved into the output register; the serializer gives one byte per cycle while
// the receiver pops, and a request has at most seven reply bytes.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and full rises; no byte is lost.
// Reset (rst, synchronous): mode flags return to joystick reporting only, the
// command parser, joystick and button history clear, and queued bytes drop.
module keyboard_controller_event_encoder_core #(
  parameter int QUEUE_DEPTH = kbe_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  kbe_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output kbe_pkg::result_t result
);
  import kbe_pkg::*;

  logic   q_push, q_full, q_pop, q_empty;
  reply_t q_wdata, q_rdata;

  kbe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  kbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  kbe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the keyboard controller event encoder core.
module testbench;
  import kbe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomRequests = 172;
  localparam int CycleLimit     = 200000;
  localparam int TailCycles     = 20;
  localparam int HoldCycles     = 150;
  localparam int HoldAfterBytes = 60;

  localparam logic [7:0] CLOCK_REPLY [7] = '{8'hFC, 8'h13, 8'h03, 8'h07, 8'h20, 8'h58, 8'h00};
  localparam logic [7:0] KNOWN_CMDS [13] = '{
    CMD_BUTTON_ACTION, CMD_MOUSE_REL, CMD_MOUSE_ABS, CMD_MOUSE_SCALE, CMD_Y_BOTTOM,
    CMD_Y_TOP, CMD_MOUSE_OFF, CMD_JOY_EVENTS, CMD_JOY_POLLED, CMD_JOY_QUERY,
    CMD_JOY_OFF, CMD_TIME_QUERY, CMD_RESET};

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    pop = 1'b0;
  logic    full;
  logic    empty;
  item_t   item = '0;
  result_t result;

  keyboard_controller_event_encoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #5 clk = ~clk;

  // Encoder state as the host side sees it
  logic [7:0] cmd_code = '0;
  logic [2:0] params_left = '0;
  logic [4:0] mode = FLAGS_RESET;
  logic [4:0] joy_hist [2] = '{5'd0, 5'd0};
  logic [1:0] btn_hist = '0;

  item_t      stim_q [$];
  result_t    host_bytes_q [$];
  logic [7:0] reply_buf [$];

  int errors = 0;
  int requests_sent = 0;
  int bytes_checked = 0;
  int full_cycles = 0;
  int cycles = 0;

  task automatic put_byte(input logic [7:0] b);
    if (reply_buf.size() < MaxBytes) reply_buf.push_back(b);
  endtask

  function automatic logic [7:0] joy_report_byte(input logic [4:0] map);
    return {map[4], 3'b000, map[3:0]};
  endfunction

  task automatic encode_mouse(input logic [1:0] buttons, input logic [7:0] dx,
                              input logic [7:0] dy);
    logic [1:0] b;
    logic [1:0] diff;
    b = buttons;
    if (mode[FL_MOUSE_OFF]) return;
    // merge the fire buttons into the mouse buttons
    if (joy_hist[0][4]) b[0] = 1'b1;
    if (joy_hist[1][4]) b[1] = 1'b1;
    diff = b ^ btn_hist;
    if (diff != 2'b00) begin
      if (mode[FL_BTN_KEYS]) begin
        if (diff[0]) put_byte({~b[0], KEY_LEFT_BTN});
        if (diff[1]) put_byte({~b[1], KEY_RIGHT_BTN});
      end
      btn_hist = b;
    end
    if (!mode[FL_ABSOLUTE]) begin
      put_byte(HDR_MOUSE_REL | {6'd0, b[0], b[1]});
      put_byte(dx);
      put_byte(mode[FL_Y_BOTTOM] ? 8'(8'h00 - dy) : dy);
    end
  endtask

  task automatic encode_joystick(input logic idx, input logic [4:0] map);
    if (mode[FL_JOY_REPORT]) begin
      if (mode[FL_MOUSE_OFF] || idx) begin
        put_byte({HDR_JOY_EVENT, idx});
        put_byte(joy_report_byte(map));
      end
      if (!mode[FL_MOUSE_OFF] && map[4] != joy_hist[idx][4]) begin
        joy_hist[idx] = map;
        encode_mouse(2'b00, 8'h00, 8'h00);
      end
    end
    joy_hist[idx] = map;
  endtask

  task automatic encode_command(input logic [7:0] c);
    if (params_left != 0) begin
      params_left = params_left - 3'd1;
      if (params_left == 0) begin
        if (cmd_code == CMD_BUTTON_ACTION) mode[FL_BTN_KEYS] = c[2];
        else if (cmd_code == CMD_RESET) put_byte(HDR_RESET_OK);
      end
      return;
    end
    cmd_code = c;
    case (c)
      CMD_BUTTON_ACTION: params_left = 3'd1;
      CMD_MOUSE_REL: begin
        mode[FL_MOUSE_OFF] = 1'b0;
        mode[FL_ABSOLUTE] = 1'b0;
      end
      CMD_MOUSE_ABS: begin
        mode[FL_MOUSE_OFF] = 1'b0;
        mode[FL_ABSOLUTE] = 1'b1;
        params_left = 3'd4;
      end
      CMD_MOUSE_SCALE: params_left = 3'd2;
      CMD_Y_BOTTOM: mode[FL_Y_BOTTOM] = 1'b1;
      CMD_Y_TOP: mode[FL_Y_BOTTOM] = 1'b0;
      CMD_MOUSE_OFF: mode[FL_MOUSE_OFF] = 1'b1;
      CMD_JOY_EVENTS: mode[FL_JOY_REPORT] = 1'b1;
      CMD_JOY_POLLED, CMD_JOY_OFF: mode[FL_JOY_REPORT] = 1'b0;
      CMD_JOY_QUERY: begin
        put_byte(HDR_JOY_STAT);
        put_byte(joy_report_byte(joy_hist[0]));
        put_byte(joy_report_byte(joy_hist[1]));
      end
      CMD_TIME_QUERY: begin
        foreach (CLOCK_REPLY[k]) put_byte(CLOCK_REPLY[k]);
      end
      CMD_RESET: begin
        params_left = 3'd1;
        mode = FLAGS_RESET;
      end
      default: ;
    endcase
  endtask

  task automatic encode_request(input item_t req);
    result_t r;
    reply_buf.delete();
    case (req.action)
      ACT_COMMAND:  encode_command(req.byte_value);
      ACT_KEY:      put_byte(req.byte_value);
      ACT_JOYSTICK: encode_joystick(req.joy_index, req.joy_map);
      default:      encode_mouse(req.btn_pressed, req.mouse_dx, req.mouse_dy);
    endcase
    foreach (reply_buf[k]) begin
      r.out_byte = reply_buf[k];
      r.last = (k == reply_buf.size() - 1);
      host_bytes_q.push_back(r);
    end
  endtask

  // Request with every field random apart from action and byte
  function automatic item_t any_item(input logic [1:0] act, input logic [7:0] bv);
    item_t it;
    it.action = act;
    it.byte_value = bv;
    it.joy_index = 1'($urandom);
    it.joy_map = 5'($urandom);
    it.btn_pressed = 2'($urandom);
    it.mouse_dx = 8'($urandom);
    it.mouse_dy = 8'($urandom);
    return it;
  endfunction

  function automatic item_t joy_item(input logic idx, input logic [4:0] map);
    item_t it;
    it = any_item(ACT_JOYSTICK, 8'($urandom));
    it.joy_index = idx;
    it.joy_map = map;
    return it;
  endfunction

  function automatic item_t mouse_item(input logic [1:0] mb, input logic [7:0] dx,
                                       input logic [7:0] dy);
    item_t it;
    it = any_item(ACT_MOUSE, 8'($urandom));
    it.btn_pressed = mb;
    it.mouse_dx = dx;
    it.mouse_dy = dy;
    return it;
  endfunction

  function automatic int param_count(input logic [7:0] c);
    case (c)
      CMD_BUTTON_ACTION, CMD_RESET: return 1;
      CMD_MOUSE_SCALE: return 2;
      CMD_MOUSE_ABS: return 4;
      default: return 0;
    endcase
  endfunction

  // Sender: hold a stalled request, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        encode_request(item);
        void'(stim_q.pop_front());
        requests_sent++;
      end
      if (push && full) begin
        full_cycles++;
      end else if (stim_q.size() != 0 &&
                   ((requests_sent >= 90 && requests_sent < 150) ||
                    $urandom_range(0, 99) >= 27)) begin
        push <= 1'b1;
        item <= stim_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: check each reply byte against the oldest expected one
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (host_bytes_q.size() == 0) begin
          $display("%0t: unexpected byte %h last %b", $time, result.out_byte, result.last);
          errors++;
        end else begin
          want = host_bytes_q.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     result.out_byte);
            errors++;
          end
          if (result.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, result.last);
            errors++;
          end
        end
        bytes_checked++;
      end
      // hold off once for a long stretch so the reply queue fills
      if (!hold_done && bytes_checked >= HoldAfterBytes) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= (bytes_checked >= 200 && bytes_checked < 300) ||
               $urandom_range(0, 99) >= 27;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    int np;
    logic [7:0] code;
    int roll;

    // directed: extremes, replies and mode changes
    stim_q.push_back(any_item(ACT_KEY, 8'h00));
    stim_q.push_back(any_item(ACT_KEY, 8'hFF));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_TIME_QUERY));
    stim_q.push_back(joy_item(1'b1, 5'h1F));
    stim_q.push_back(joy_item(1'b0, 5'h10));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_JOY_QUERY));
    stim_q.push_back(mouse_item(2'b11, 8'h7F, 8'h80));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_Y_BOTTOM));
    stim_q.push_back(mouse_item(2'b00, 8'h80, 8'h80));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_BUTTON_ACTION));
    stim_q.push_back(any_item(ACT_COMMAND, 8'h04));
    stim_q.push_back(joy_item(1'b0, 5'h00));
    stim_q.push_back(joy_item(1'b1, 5'h0F));
    stim_q.push_back(mouse_item(2'b01, 8'h01, 8'h7F));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_MOUSE_ABS));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_RESET));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_JOY_QUERY));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_TIME_QUERY));
    stim_q.push_back(any_item(ACT_COMMAND, 8'hFF));
    stim_q.push_back(mouse_item(2'b10, 8'h05, 8'h06));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_MOUSE_OFF));
    stim_q.push_back(joy_item(1'b0, 5'h1A));
    stim_q.push_back(mouse_item(2'b11, 8'h10, 8'h20));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_JOY_POLLED));
    stim_q.push_back(joy_item(1'b1, 5'h05));
    stim_q.push_back(any_item(ACT_COMMAND, CMD_RESET));
    stim_q.push_back(any_item(ACT_COMMAND, 8'h33));
    stim_q.push_back(any_item(ACT_COMMAND, 8'h55));

    // random: commands (mostly well-formed, with random parameters), keys, joystick and mouse events
    n = 0;
    while (n < RandomRequests) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        if ($urandom_range(0, 9) == 0) code = 8'($urandom);
        else code = KNOWN_CMDS[$urandom_range(0, 12)];
        np = param_count(code);
        // drop parameters now and then to break the sequence
        if ($urandom_range(0, 9) == 0) np = $urandom_range(0, np);
        stim_q.push_back(any_item(ACT_COMMAND, code));
        n++;
        repeat (np) begin
          stim_q.push_back(any_item(ACT_COMMAND, 8'($urandom)));
          n++;
        end
      end else if (roll < 50) begin
        stim_q.push_back(any_item(ACT_KEY, 8'($urandom)));
        n++;
      end else if (roll < 75) begin
        stim_q.push_back(any_item(ACT_JOYSTICK, 8'($urandom)));
        n++;
      end else begin
        stim_q.push_back(any_item(ACT_MOUSE, 8'($urandom)));
        n++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || push) @(posedge clk);
    while (host_bytes_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d requests, checked %0d reply bytes, input held off on %0d cycles",
             requests_sent, bytes_checked, full_cycles);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
